>>> rtl/core/buih_pkg.sv
// ============================================================================
// buih_pkg: shared constants for the block update interval histogram
// Request codes, interval unit divisor and counter limits.
// ============================================================================
package buih_pkg;

    // request codes carried on func
    localparam logic [1:0] FN_READ    = 2'd0;
    localparam logic [1:0] FN_WRITE   = 2'd1;
    localparam logic [1:0] FN_READOUT = 2'd2;

    // one interval unit is 0.1 s, i.e. 1000000 ticks of 100 ns
    localparam int          REM_W          = 20;
    localparam logic [19:0] TICKS_PER_UNIT = 20'd1000000;

    // 1000000 = 15625 * 2**6: drop the power of two by a shift, divide the odd part
    localparam int          UNIT_SHIFT = 6;
    localparam int          ODD_W      = 14;
    localparam logic [13:0] UNIT_ODD   = 14'd15625;

    // saturation value of every counter
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

>>> rtl/core/block_update_interval_histogram_core.sv
// ============================================================================
// block_update_interval_histogram_core: reuse time histogram of block writes
// Walks the blocks of each write request and bins the time since each
// block's previous write; answers histogram bin readouts.
// ============================================================================
// Usage
//   Request channel: present func, start_block, block_count, timestamp and
//   bin_index with start high; the request is taken at a clock edge where
//   busy is low. busy stays high until the request is finished.
//   Result channel: done is high for exactly one cycle with bin_count,
//   skipped_total and range_error. Every request gives one result. The
//   receiver cannot stall; sample the result while done is high.
// Sequencing
//   Read request, zero length write and out-of-range readout: answered
//   straight from idle. Readout: reads the bin memory, then returns the count.
//   Write: one walk per covered block, one block at a time. A block never
//   written before, or one whose stored time is later, only has its new
//   time written; an interval of HIST_BINS units or more goes straight to
//   the last bin; any other binned block first passes the reciprocal
//   multiply by 1/1000000, then the read-modify-write of the bin memory.
//   The walk ends at the first block beyond the table.
// Reset
//   After rst_n rises, a clearing pass over max(BLOCKS, HIST_BINS) entries
//   zeroes the written flags and the histogram; busy is high meanwhile.
// ============================================================================
module block_update_interval_histogram_core
    import buih_pkg::*;
#(
    parameter int BLOCKS    = 65536,
    parameter int HIST_BINS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [15:0] start_block,
    input  logic [16:0] block_count,
    input  logic [63:0] timestamp,
    input  logic [15:0] bin_index,
    output logic        done,
    output logic [31:0] bin_count,
    output logic [31:0] skipped_total,
    output logic        range_error
);

    localparam int BLK_AW = $clog2(BLOCKS);
    localparam int BIN_AW = $clog2(HIST_BINS);
    localparam int CLR_N  = (BLOCKS > HIST_BINS) ? BLOCKS : HIST_BINS;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int DIV_W  = BIN_AW + REM_W;
    localparam int BLK_DW = 65;

    // intervals of HIST_BINS units or more land in the last bin
    localparam logic [63:0]       LIMIT    = 64'(HIST_BINS) * 64'(TICKS_PER_UNIT);
    localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(HIST_BINS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_RANGE,
        ST_DIV,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_NEXT,
        ST_OUT_RD,
        ST_OUT_DATA
    } state_t;

    state_t              state_reg;
    logic [CLR_W-1:0]    clr_reg;
    logic [63:0]         now_reg;
    logic [16:0]         blk_reg;
    logic [16:0]         left_reg;
    logic [63:0]         elapsed_reg;
    logic [BIN_AW-1:0]   bin_reg;
    logic [31:0]         skip_reg;
    logic                done_reg;
    logic [31:0]         bin_count_reg;
    logic                range_error_reg;

    // block memory: {written flag, last write time}
    logic                blk_we;
    logic [BLK_AW-1:0]   blk_waddr;
    logic [BLK_DW-1:0]   blk_wdata;
    logic [BLK_DW-1:0]   blk_rdata;

    // histogram memory
    logic                bin_we;
    logic [BIN_AW-1:0]   bin_waddr;
    logic [31:0]         bin_wdata;
    logic [31:0]         bin_rdata;
    logic [31:0]         bin_inc;

    logic [64:0]         diff;
    logic                blk_in_table;
    logic                clearing;
    logic                div_start;
    logic                div_done;
    logic [BIN_AW-1:0]   div_quot;

    assign clearing     = (state_reg == ST_CLEAR);
    assign blk_in_table = (32'(blk_reg) < 32'(BLOCKS));

    // borrow of now - prev marks a stored time later than the request
    assign diff    = {1'b0, now_reg} - {1'b0, blk_rdata[63:0]};
    assign bin_inc = (bin_rdata == CNT_MAX) ? bin_rdata : bin_rdata + 32'd1;

    // write back the new time while the check looks at the old one
    assign blk_we    = clearing ? (32'(clr_reg) < 32'(BLOCKS)) : (state_reg == ST_CHECK);
    assign blk_waddr = clearing ? BLK_AW'(clr_reg) : BLK_AW'(blk_reg);
    assign blk_wdata = clearing ? '0 : {1'b1, now_reg};

    assign bin_we    = clearing ? (32'(clr_reg) < 32'(HIST_BINS)) : (state_reg == ST_BIN_WR);
    assign bin_waddr = clearing ? BIN_AW'(clr_reg) : bin_reg;
    assign bin_wdata = clearing ? '0 : bin_inc;

    assign div_start = (state_reg == ST_RANGE) && (elapsed_reg < LIMIT);

    buih_ram #(
        .WIDTH (BLK_DW),
        .DEPTH (BLOCKS)
    ) u_blk_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .raddr (BLK_AW'(blk_reg)),
        .rdata (blk_rdata)
    );

    buih_ram #(
        .WIDTH (32),
        .DEPTH (HIST_BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_reg),
        .rdata (bin_rdata)
    );

    // the power-of-two part of the unit is dropped on the way in
    buih_div #(
        .QW (BIN_AW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_reg[DIV_W-1:UNIT_SHIFT]),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            skip_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    // sweep both memories, one entry a cycle
                    if (clr_reg == CLR_W'(CLR_N - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + CLR_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        now_reg  <= timestamp;
                        blk_reg  <= {1'b0, start_block};
                        left_reg <= block_count;
                        bin_reg  <= BIN_AW'(bin_index);
                        case (func)
                            FN_WRITE:
                            begin
                                if (block_count == 17'd0)
                                begin
                                    done_reg        <= 1'b1;
                                    bin_count_reg   <= '0;
                                    range_error_reg <= 1'b0;
                                end
                                else
                                begin
                                    state_reg <= ST_WALK;
                                end
                            end
                            FN_READOUT:
                            begin
                                if (32'(bin_index) < 32'(HIST_BINS))
                                begin
                                    state_reg <= ST_OUT_RD;
                                end
                                else
                                begin
                                    done_reg        <= 1'b1;
                                    bin_count_reg   <= '0;
                                    range_error_reg <= 1'b0;
                                end
                            end
                            default:
                            begin
                                // trace reads and the unused code change nothing
                                done_reg        <= 1'b1;
                                bin_count_reg   <= '0;
                                range_error_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_WALK:
                begin
                    // addresses only grow, so the first block off the table ends the walk
                    if (blk_in_table)
                    begin
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        done_reg        <= 1'b1;
                        bin_count_reg   <= '0;
                        range_error_reg <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                ST_CHECK:
                begin
                    if (!blk_rdata[BLK_DW-1])
                    begin
                        state_reg <= ST_NEXT;
                    end
                    else if (diff[64])
                    begin
                        if (skip_reg != CNT_MAX)
                        begin
                            skip_reg <= skip_reg + 32'd1;
                        end
                        state_reg <= ST_NEXT;
                    end
                    else
                    begin
                        elapsed_reg <= diff[63:0];
                        state_reg   <= ST_RANGE;
                    end
                end
                ST_RANGE:
                begin
                    if (elapsed_reg >= LIMIT)
                    begin
                        bin_reg   <= LAST_BIN;
                        state_reg <= ST_BIN_RD;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        bin_reg   <= div_quot;
                        state_reg <= ST_BIN_RD;
                    end
                end
                ST_BIN_RD:
                begin
                    state_reg <= ST_BIN_WR;
                end
                ST_BIN_WR:
                begin
                    state_reg <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if (left_reg == 17'd1)
                    begin
                        done_reg        <= 1'b1;
                        bin_count_reg   <= '0;
                        range_error_reg <= 1'b0;
                        state_reg       <= ST_IDLE;
                    end
                    else
                    begin
                        left_reg  <= left_reg - 17'd1;
                        blk_reg   <= blk_reg + 17'd1;
                        state_reg <= ST_WALK;
                    end
                end
                ST_OUT_RD:
                begin
                    state_reg <= ST_OUT_DATA;
                end
                ST_OUT_DATA:
                begin
                    done_reg        <= 1'b1;
                    bin_count_reg   <= bin_rdata;
                    range_error_reg <= 1'b0;
                    state_reg       <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign bin_count     = bin_count_reg;
    assign skipped_total = skip_reg;
    assign range_error   = range_error_reg;

endmodule

>>> rtl/core/buih_ram.sv
// ============================================================================
// buih_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ============================================================================
module buih_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/buih_div.sv
// ============================================================================
// buih_div: divider by the interval unit
// Reciprocal multiplication of the interval, already shifted right by
// UNIT_SHIFT, by 1/15625; 16 bits of the dividend per cycle, most
// significant first; done rises together with the quotient.
// The dividend must stay below 2**QW interval units.
// ============================================================================
module buih_div
    import buih_pkg::*;
#(
    parameter int QW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [QW+ODD_W-1:0]   dividend,
    output logic                  done,
    output logic [QW-1:0]         quot
);

    localparam int YW  = QW + ODD_W;
    localparam int NCH = (YW + 15) / 16;
    localparam int YP  = NCH * 16;
    localparam int K   = YW + ODD_W;
    localparam int MW  = YW + 1;
    localparam int AW  = YP + MW;
    localparam int PW  = 16 + MW;
    localparam int CW  = $clog2(NCH + 1);

    // ceil(2**K / 15625): exact for every dividend below 2**YW
    localparam logic [63:0]   RECIP64 =
        ((64'd1 << K) + 64'(UNIT_ODD) - 64'd1) / 64'(UNIT_ODD);
    localparam logic [MW-1:0] RECIP   = RECIP64[MW-1:0];

    logic [YP-1:0] y_reg;
    logic [AW-1:0] acc_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [PW-1:0] part;

    // top chunk of the remaining dividend times the reciprocal
    assign part = PW'(y_reg[YP-1 -: 16]) * PW'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                y_reg   <= YP'(dividend);
                acc_reg <= '0;
                cnt_reg <= CW'(NCH);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                acc_reg <= (acc_reg << 16) + AW'(part);
                y_reg   <= y_reg << 16;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = acc_reg[K +: QW];

endmodule

>>> rtl/core/buih_checker.sv
// ============================================================================
// buih_checker: port-level checks for the interval histogram core
// Watches the request and result ports only; bound to the top level.
// ============================================================================
module buih_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic [31:0] bin_count,
    input  logic [31:0] skipped_total,
    input  logic        range_error
);

    // a taken request either finishes at once or holds busy
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("request taken but neither done nor busy");

    // range errors come from writes, which never carry a bin count
    a_err_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_error) |-> (bin_count == 32'd0))
        else $error("range error reported with a nonzero bin count");

    // the skip total saturates and never falls
    a_skip_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (skipped_total >= $past(skipped_total)))
        else $error("skip total decreased");

    // skips are only counted while a request is in progress
    a_skip_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(busy) |-> $stable(skipped_total))
        else $error("skip total changed while idle");

endmodule

bind block_update_interval_histogram_core buih_checker u_buih_checker (.*);
